@@ design/rv32_alu_pkg.sv @@
// rv32_alu_pkg: types, operation codes and sizes for the rv32im execute unit
// no dependencies; imported by the execute core and its checker
`timescale 1ns / 1ps

package rv32_alu_pkg;

    localparam int XLEN      = 32;
    localparam int CMD_W     = 6;
    // one quotient bit per divider stage
    localparam int DIV_STEPS = XLEN;

    typedef enum logic [CMD_W-1:0] {
        OP_ADD    = 6'd0,  OP_SUB   = 6'd1,  OP_XOR   = 6'd2,  OP_OR    = 6'd3,
        OP_AND    = 6'd4,  OP_SLL   = 6'd5,  OP_SRL   = 6'd6,  OP_SRA   = 6'd7,
        OP_SLT    = 6'd8,  OP_SLTU  = 6'd9,  OP_MUL   = 6'd10, OP_MULH  = 6'd11,
        OP_MULHSU = 6'd12, OP_MULHU = 6'd13, OP_DIV   = 6'd14, OP_DIVU  = 6'd15,
        OP_REM    = 6'd16, OP_REMU  = 6'd17, OP_ADDI  = 6'd18, OP_XORI  = 6'd19,
        OP_ORI    = 6'd20, OP_ANDI  = 6'd21, OP_SLLI  = 6'd22, OP_SRLI  = 6'd23,
        OP_SRAI   = 6'd24, OP_SLTI  = 6'd25, OP_SLTIU = 6'd26, OP_BEQ   = 6'd27,
        OP_BNE    = 6'd28, OP_BLT   = 6'd29, OP_BGE   = 6'd30, OP_BLTU  = 6'd31,
        OP_BGEU   = 6'd32, OP_LUI   = 6'd33, OP_AUIPC = 6'd34, OP_LB    = 6'd35,
        OP_LH     = 6'd36, OP_LW    = 6'd37, OP_LBU   = 6'd38, OP_LHU   = 6'd39
    } op_t;

    typedef struct packed {
        logic [CMD_W-1:0]       command;
        logic [XLEN-1:0]        operand_a;
        logic [XLEN-1:0]        operand_b;
        logic signed [XLEN-1:0] immediate;
    } alu_in_t;

    typedef struct packed {
        logic [XLEN-1:0] result_value;
        logic            branch_taken;
        logic            illegal_op;
    } alu_out_t;

    // payload carried through the product and divider stages
    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [XLEN-1:0]   op_a;
        logic [XLEN-1:0]   val;
        logic              taken;
        logic              illegal;
        logic [2*XLEN-1:0] prod;
        logic [XLEN-1:0]   mcorr;
        logic [XLEN-1:0]   rem;
        logic [XLEN-1:0]   quo;
        logic [XLEN-1:0]   dvs;
        logic              neg_q;
        logic              neg_r;
        logic              b_zero;
        logic              ovf;
    } alu_stage_t;

endpackage

@@ design/rv32im_execute_alu_core.sv @@
// rv32im_execute_alu_core: pipelined rv32im execute unit with radix-2 divider stages
// depends on rv32_alu_pkg
`timescale 1ns / 1ps
//
//  channel | ports                      | payload
//  --------+----------------------------+------------------------------------
//  input   | s_valid, s_ready, s_data   | alu_in_t  (command, operands, imm)
//  result  | m_valid, m_ready, m_data   | alu_out_t (value, taken, illegal)
//
//  every command passes 35 registers: the input register, one stage with the
//  unsigned 32x32 multiplier and the simple alu, 32 divider stages at one
//  quotient bit each, and the output register. signed high products are
//  corrected at the output. one item enters per cycle while the pipeline
//  is not held; the whole pipeline holds while a result waits on m_ready.
//  aresetn clears all valid bits; payload registers are not reset.

module rv32im_execute_alu_core
    import rv32_alu_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  alu_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output alu_out_t m_data
);

    localparam int NSTG = DIV_STEPS + 1;

    logic       en;
    logic       p_valid_reg;
    alu_in_t    p_reg;
    logic       d_valid_reg [NSTG];
    alu_stage_t d_reg       [NSTG];
    alu_stage_t d_next      [NSTG];
    logic       m_valid_reg;
    alu_out_t   m_data_reg;
    alu_out_t   m_data_next;

    // pipeline advances unless the output holds an untaken result
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // prep stage: simple alu, branch compare, multiplier, divider setup
    always_comb begin
        logic [XLEN-1:0]   a, b, imm;
        logic [4:0]        shb, shi;
        logic              sa, sb, sdiv, mhi_a, mhi_b;
        logic [2*XLEN-1:0] mp;
        a     = p_reg.operand_a;
        b     = p_reg.operand_b;
        imm   = p_reg.immediate;
        shb   = b[4:0];
        shi   = imm[4:0];
        sa    = a[XLEN-1];
        sb    = b[XLEN-1];
        d_next[0] = '0;
        d_next[0].cmd  = p_reg.command;
        d_next[0].op_a = a;
        unique case (p_reg.command)
            OP_ADD:    d_next[0].val = a + b;
            OP_SUB:    d_next[0].val = a - b;
            OP_XOR:    d_next[0].val = a ^ b;
            OP_OR:     d_next[0].val = a | b;
            OP_AND:    d_next[0].val = a & b;
            OP_SLL:    d_next[0].val = a << shb;
            OP_SRL:    d_next[0].val = a >> shb;
            OP_SRA:    d_next[0].val = $unsigned($signed(a) >>> shb);
            OP_SLT:    d_next[0].val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(b)};
            OP_SLTU:   d_next[0].val = {{(XLEN-1){1'b0}}, a < b};
            OP_MUL, OP_MULH, OP_MULHSU, OP_MULHU,
            OP_DIV, OP_DIVU, OP_REM, OP_REMU: d_next[0].val = '0;
            OP_ADDI:   d_next[0].val = a + imm;
            OP_XORI:   d_next[0].val = a ^ imm;
            OP_ORI:    d_next[0].val = a | imm;
            OP_ANDI:   d_next[0].val = a & imm;
            OP_SLLI:   d_next[0].val = a << shi;
            OP_SRLI:   d_next[0].val = a >> shi;
            OP_SRAI:   d_next[0].val = $unsigned($signed(a) >>> shi);
            OP_SLTI:   d_next[0].val = {{(XLEN-1){1'b0}}, $signed(a) < $signed(imm)};
            OP_SLTIU:  d_next[0].val = {{(XLEN-1){1'b0}}, a < imm};
            OP_BEQ:    d_next[0].taken = (a == b);
            OP_BNE:    d_next[0].taken = (a != b);
            OP_BLT:    d_next[0].taken = ($signed(a) < $signed(b));
            OP_BGE:    d_next[0].taken = !($signed(a) < $signed(b));
            OP_BLTU:   d_next[0].taken = (a < b);
            OP_BGEU:   d_next[0].taken = (a >= b);
            OP_LUI:    d_next[0].val = imm;
            OP_AUIPC:  d_next[0].val = a + imm;
            OP_LB:     d_next[0].val = {{(XLEN-8){a[7]}}, a[7:0]};
            OP_LH:     d_next[0].val = {{(XLEN-16){a[15]}}, a[15:0]};
            OP_LW:     d_next[0].val = a;
            OP_LBU:    d_next[0].val = {{(XLEN-8){1'b0}}, a[7:0]};
            OP_LHU:    d_next[0].val = {{(XLEN-16){1'b0}}, a[15:0]};
            default:   d_next[0].illegal = 1'b1;
        endcase
        // unsigned multiplier; high word fix-up for signed operands kept for the output
        mhi_a = (p_reg.command == OP_MULH) || (p_reg.command == OP_MULHSU);
        mhi_b = (p_reg.command == OP_MULH);
        mp    = {{XLEN{1'b0}}, a} * {{XLEN{1'b0}}, b};
        d_next[0].prod  = mp;
        d_next[0].mcorr = ((mhi_a && sa) ? b : '0) + ((mhi_b && sb) ? a : '0);
        // divider setup on magnitudes for the signed forms
        sdiv  = (p_reg.command == OP_DIV) || (p_reg.command == OP_REM);
        d_next[0].quo    = (sdiv && sa) ? (~a + 1'b1) : a;
        d_next[0].dvs    = (sdiv && sb) ? (~b + 1'b1) : b;
        d_next[0].rem    = '0;
        d_next[0].neg_q  = sdiv && (sa ^ sb);
        d_next[0].neg_r  = sdiv && sa;
        d_next[0].b_zero = (b == '0);
        d_next[0].ovf    = (a == {1'b1, {(XLEN-1){1'b0}}}) && (b == '1);
    end

    // restoring divider: one quotient bit per stage
    for (genvar i = 1; i < NSTG; i++) begin : g_div
        always_comb begin
            logic [XLEN:0] trial;
            logic [XLEN:0] diff;
            d_next[i] = d_reg[i-1];
            trial = {d_reg[i-1].rem, d_reg[i-1].quo[XLEN-1]};
            diff  = trial - {1'b0, d_reg[i-1].dvs};
            if (!diff[XLEN]) begin
                d_next[i].rem = diff[XLEN-1:0];
                d_next[i].quo = {d_reg[i-1].quo[XLEN-2:0], 1'b1};
            end else begin
                d_next[i].rem = trial[XLEN-1:0];
                d_next[i].quo = {d_reg[i-1].quo[XLEN-2:0], 1'b0};
            end
        end
    end

    // final select with division special cases
    always_comb begin
        alu_stage_t f;
        logic [XLEN-1:0] q, r;
        f = d_reg[NSTG-1];
        q = f.neg_q ? (~f.quo + 1'b1) : f.quo;
        r = f.neg_r ? (~f.rem + 1'b1) : f.rem;
        m_data_next.branch_taken = f.taken;
        m_data_next.illegal_op   = f.illegal;
        unique case (f.cmd)
            OP_MUL:    m_data_next.result_value = f.prod[XLEN-1:0];
            OP_MULH, OP_MULHSU, OP_MULHU:
                       m_data_next.result_value = f.prod[2*XLEN-1:XLEN] - f.mcorr;
            OP_DIV:    m_data_next.result_value = f.b_zero ? '1 : (f.ovf ? f.op_a : q);
            OP_DIVU:   m_data_next.result_value = f.b_zero ? '1 : f.quo;
            OP_REM:    m_data_next.result_value = f.b_zero ? f.op_a : (f.ovf ? '0 : r);
            OP_REMU:   m_data_next.result_value = f.b_zero ? f.op_a : f.rem;
            default:   m_data_next.result_value = f.val;
        endcase
    end

    // pipeline registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
            for (int k = 0; k < NSTG; k++) begin
                d_valid_reg[k] <= 1'b0;
            end
        end else if (en) begin
            p_valid_reg    <= s_valid;
            d_valid_reg[0] <= p_valid_reg;
            for (int k = 1; k < NSTG; k++) begin
                d_valid_reg[k] <= d_valid_reg[k-1];
            end
            m_valid_reg <= d_valid_reg[NSTG-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg <= s_data;
            for (int k = 0; k < NSTG; k++) begin
                d_reg[k] <= d_next[k];
            end
            m_data_reg <= m_data_next;
        end
    end

endmodule

@@ design/rv32_alu_checker.sv @@
// rv32_alu_checker: port-level assertions for the execute core, bound to the top
// depends on rv32_alu_pkg and rv32im_execute_alu_core
`timescale 1ns / 1ps

module rv32_alu_checker
    import rv32_alu_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_ready,
    input logic     m_valid,
    input logic     m_ready,
    input alu_out_t m_data
);

    // a result waiting on the sink stays up
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // and keeps its payload
    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_data))
        else $error("result payload changed while stalled");

    // unknown commands produce no value and no branch
    a_illegal_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.illegal_op |-> m_data.result_value == '0 && !m_data.branch_taken)
        else $error("illegal command gave a nonzero result");

    // a taken branch carries a zero value
    a_branch_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.branch_taken |-> m_data.result_value == '0 && !m_data.illegal_op)
        else $error("taken branch with nonzero value");

    // input is refused only while a result stalls at the output
    a_ready_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output backpressure");

endmodule

bind rv32im_execute_alu_core rv32_alu_checker u_rv32_alu_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
